/* hdl/lbmc_pkg.sv */
`default_nettype none

package lbmc_pkg;

    // blend modes, codes above difference behave as normal
    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_MULTIPLY   = 3'd1,
        MODE_SCREEN     = 3'd2,
        MODE_OVERLAY    = 3'd3,
        MODE_DIFFERENCE = 3'd4
    } t_mode;

    // configuration register indexes
    localparam logic C_REG_MODE    = 1'b0;
    localparam logic C_REG_OPACITY = 1'b1;

    localparam int C_CHAN_W  = 8;
    localparam int C_OPAC_W  = 9;
    localparam int C_IN_W    = 7 * C_CHAN_W;
    localparam int C_OUT_W   = 3 * C_CHAN_W;
    localparam int C_STAGES  = 6;

    localparam logic [7:0]  C_CHAN_MAX    = 8'd255;
    localparam logic [7:0]  C_SPLIT       = 8'd128;
    localparam logic [8:0]  C_OPACITY_ONE = 9'd256;
    localparam logic [15:0] C_FULL_SCALE  = 16'd65280;  // 255 * 256
    localparam logic [15:0] C_CHAN_SQ     = 16'd65025;  // 255 * 255
    // floor(2^32 / 65025), off by at most one after the shift
    localparam logic [16:0] C_RECIP       = 17'd66051;

    // per-stage advance strobes handed to each lane
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
        logic en_s4;
        logic en_s5;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* hdl/lbmc_lane.sv */
`default_nettype none

module lbmc_lane (
    input  wire                     i_clk,
    input  lbmc_pkg::t_lane_ctl     i_ctl,
    input  lbmc_pkg::t_mode         i_mode,
    input  wire  [15:0]             i_ao,
    input  wire  [7:0]              i_base,
    input  wire  [7:0]              i_top,
    output logic [7:0]              o_chan
);
    import lbmc_pkg::*;

    logic [7:0]  r_b1, r_t1;
    logic [15:0] r_v2;
    logic [7:0]  r_b2;
    logic [31:0] r_pb3, r_pt3;
    logic [23:0] r_x4;
    logic [23:0] r_x5;
    logic [7:0]  r_q5;

    logic [7:0]  ib, it, diff;
    logic [15:0] bt, ibit, n_v;
    logic [15:0] b255, inv_ao;
    logic [31:0] sum;
    logic [40:0] prod;
    logic [23:0] qm, rem;
    logic [8:0]  q;

    // blend value, scaled by 255
    always_comb begin
        ib   = C_CHAN_MAX - r_b1;
        it   = C_CHAN_MAX - r_t1;
        diff = (r_b1 >= r_t1) ? (r_b1 - r_t1) : (r_t1 - r_b1);
        bt   = 16'(r_b1) * 16'(r_t1);
        ibit = 16'(ib) * 16'(it);
        unique case (i_mode)
            MODE_MULTIPLY:   n_v = bt;
            MODE_SCREEN:     n_v = C_CHAN_SQ - ibit;
            MODE_OVERLAY: begin
                if (r_b1 < C_SPLIT) n_v = {bt[14:0], 1'b0};
                else                n_v = C_CHAN_SQ - {ibit[14:0], 1'b0};
            end
            MODE_DIFFERENCE: n_v = {diff, 8'h00} - 16'(diff);
            default:         n_v = {r_t1, 8'h00} - 16'(r_t1);
        endcase
    end

    assign b255   = {r_b2, 8'h00} - 16'(r_b2);
    assign inv_ao = C_FULL_SCALE - i_ao;
    assign sum    = r_pb3 + r_pt3;
    assign prod   = 41'(r_x4) * 41'(C_RECIP);

    // quotient correction, estimate is low by at most one
    assign qm  = 24'(r_q5) * 24'(C_CHAN_SQ);
    assign rem = r_x5 - qm;
    assign q   = (rem >= 24'(C_CHAN_SQ)) ? (9'(r_q5) + 9'd1) : 9'(r_q5);
    assign o_chan = q[8] ? C_CHAN_MAX : q[7:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r_b1 <= i_base;
            r_t1 <= i_top;
        end
        if (i_ctl.en_s2) begin
            r_v2 <= n_v;
            r_b2 <= r_b1;
        end
        if (i_ctl.en_s3) begin
            r_pb3 <= 32'(b255) * 32'(inv_ao);
            r_pt3 <= 32'(r_v2) * 32'(i_ao);
        end
        if (i_ctl.en_s4) begin
            r_x4 <= sum[31:8];
        end
        if (i_ctl.en_s5) begin
            r_q5 <= prod[39:32];
            r_x5 <= r_x4;
        end
    end

endmodule

`default_nettype wire

/* hdl/layer_blend_mode_compositor.sv */
`default_nettype none

// layer blend compositor: blends one top-layer pixel over one base pixel per word,
// blue, green and red each in a lane of their own, in the mode set by the mode
// register (normal, multiply, screen, overlay, difference; codes 5..7 act as
// normal). effective alpha is top_alpha/255 times opacity/256, opacity above 256
// counts as 256. each channel gives floor((B*255*(65280-A*O) + V*A*O) / 16646400)
// saturated to 0..255; base alpha is not used and output alpha is implied opaque.
// throughput is one word per clock while the output is not stalled; a word taken passes
// through the six-register pipeline: input, blend value, the two 16x16 products,
// sum and reciprocal multiply in each lane, then the output register that the
// correction feeds. a stall at the output only backs up stages that hold data, so
// bubbles are squeezed out and input is taken while a result waits as long as a
// stage is empty. the user must see that configuration is written only while the
// block is idle; the block itself does not enforce it.
module layer_blend_mode_compositor (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration
    input  wire          i_cfg_we,
    input  wire          i_cfg_index,
    input  wire  [8:0]   i_cfg_wdata,
    // input stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // base_blue, base_green, base_red, top_blue, top_green, top_red, top_alpha
    input  wire  [55:0]  i_s_tdata,
    // output stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // out_blue, out_green, out_red
    output logic [23:0]  o_m_tdata
);
    import lbmc_pkg::*;

    // configuration registers
    logic [2:0]  r_mode;
    logic [8:0]  r_opacity;

    // valid bit per pipeline stage, stage 6 is the output register
    logic [C_STAGES:1] r_vld;
    logic [C_STAGES:1] en;

    logic [15:0] r_ao1, r_ao2;
    logic [23:0] r_out;
    logic [8:0]  op_sat;
    t_lane_ctl   lane_ctl;
    logic [7:0]  chan [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NORMAL;
            r_opacity <= C_OPACITY_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                C_REG_MODE:    r_mode    <= i_cfg_wdata[2:0];
                C_REG_OPACITY: r_opacity <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[C_STAGES] = !r_vld[C_STAGES] || i_m_tready;
        for (int k = C_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_s_tvalid;
            for (int k = 2; k <= C_STAGES; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // combined alpha, shared by all three lanes
    assign op_sat = (r_opacity > C_OPACITY_ONE) ? C_OPACITY_ONE : r_opacity;

    always_ff @(posedge i_clk) begin
        if (en[1]) r_ao1 <= 16'(i_s_tdata[55:48]) * 16'(op_sat);
        if (en[2]) r_ao2 <= r_ao1;
    end

    assign lane_ctl = '{en_s1: en[1], en_s2: en[2], en_s3: en[3],
                        en_s4: en[4], en_s5: en[5]};

    for (genvar g = 0; g < 3; g++) begin : g_lane
        lbmc_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_mode (t_mode'(r_mode)),
            .i_ao   (r_ao2),
            .i_base (i_s_tdata[g*8 +: 8]),
            .i_top  (i_s_tdata[24 + g*8 +: 8]),
            .o_chan (chan[g])
        );
    end

    // merge the three lanes into the output word
    always_ff @(posedge i_clk) begin
        if (en[C_STAGES]) r_out <= {chan[2], chan[1], chan[0]};
    end

    assign o_m_tvalid = r_vld[C_STAGES];
    assign o_m_tdata  = r_out;

endmodule

`default_nettype wire

/* hdl/lbmc_checker.sv */
`default_nettype none

module lbmc_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          o_s_tready,
    input  wire  [55:0]  i_s_tdata,
    input  wire          o_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [23:0]  o_m_tdata
);

    // a stalled output word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output word changed");

    // nothing comes out right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // input side is never blocked while the output can move
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with free output");

    // a fully transparent top pixel passes the base through while the output stays ready
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tdata[55:48] == 8'd0)
        ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        |=> (o_m_tvalid && o_m_tdata == $past(i_s_tdata[23:0], 6)))
        else $error("transparent pixel did not pass base");

endmodule

bind layer_blend_mode_compositor lbmc_checker u_lbmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
